// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Each use names a label, a property and a message.
// The clock is clk and the synchronous active-low reset is rst_n in every user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define TMB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, including those in reset.
`define TMB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tmb_pkg.sv
`default_nettype none

package tmb_pkg;

  localparam int MAP_SIDE  = 8;
  localparam int CELLS     = MAP_SIDE * MAP_SIDE;
  localparam int COORD_W   = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;
  localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int MAX_BLITS = 64;
  localparam int CNT_W     = $clog2(MAX_BLITS + 1);

  localparam int TPX_W      = 8;
  localparam int TPR_W      = 9;
  localparam int ZOOM_W     = 5;
  localparam int SIDE_W     = TPX_W + ZOOM_W;
  localparam int TILE_W     = 16;
  localparam int IN_COORD_W = 8;
  localparam int DXY_W      = 16;
  localparam int DSIDE_W    = 12;
  localparam int SX_W       = 16;
  localparam int SY_W       = 23;
  localparam int PROD_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [TILE_W-1:0] EMPTY_CELL = '1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TILE_PIXELS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILES_PER_ROW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_FACTOR   = 2'd2;

  localparam logic [TPX_W-1:0]  TPX_RESET  = 8'd32;
  localparam logic [TPR_W-1:0]  TPR_RESET  = 9'd8;
  localparam logic [ZOOM_W-1:0] ZOOM_RESET = 5'd1;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [TILE_W-1:0] data;
  } ram_wr_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(row) * ADDR_W'(MAP_SIDE) + ADDR_W'(col);
    return a;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tile_map_blit_address_generator.sv
// Tile map blit address generator. A write request (command 0) stores a tile number in one
// map cell and gives no result; writes outside the map are dropped. A draw request
// (command 1) walks the map in row-major order out of a RAM with a registered read, and
// emits one blit command per occupied cell, each on the out_ ports for exactly one cycle
// with out_valid high; the receiver cannot stall, so it must take every result as it comes.
// The final command of a draw has out_last set, and a draw over an empty map gives nothing.
// busy stays high after a draw request until the walk is over; it falls in the cycle that
// carries the last result. A draw makes one setup step, then reads and checks each cell;
// an occupied cell also goes through the source divider, which flags its done, and the
// multiply step, and a closing step follows when anything is drawn. The map reads as
// empty after reset with no clearing pass, so requests are taken from the first cycle
// after reset.
`default_nettype none

`include "assert_macros.svh"

module tile_map_blit_address_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [tmb_pkg::IN_COORD_W-1:0]    in_col,
  input  logic [tmb_pkg::IN_COORD_W-1:0]    in_row,
  input  logic signed [tmb_pkg::TILE_W-1:0] in_tile,
  output logic                              out_valid,
  output logic [tmb_pkg::DXY_W-1:0]         out_dest_x,
  output logic [tmb_pkg::DXY_W-1:0]         out_dest_y,
  output logic [tmb_pkg::DSIDE_W-1:0]       out_dest_side,
  output logic [tmb_pkg::SX_W-1:0]          out_src_x,
  output logic [tmb_pkg::SY_W-1:0]          out_src_y,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tmb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tmb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_READ, S_CHECK, S_DIV, S_MUL, S_FLUSH
  } state_t;

  localparam logic [CNT_W-1:0]   MAX_CNT  = CNT_W'(MAX_BLITS);
  localparam logic [COORD_W-1:0] LAST_POS = COORD_W'(MAP_SIDE - 1);

  state_t             state_r;
  logic [TPX_W-1:0]   tpx_r;
  logic [TPR_W-1:0]   tpr_r;
  logic [ZOOM_W-1:0]  zoom_r;
  logic [SIDE_W-1:0]  side_r;
  logic [TPR_W-1:0]   per_row_r;
  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;
  logic [CNT_W-1:0]   found_r;

  logic               pend_vld_r;
  logic [DXY_W-1:0]   pend_dx_r;
  logic [DXY_W-1:0]   pend_dy_r;
  logic [SX_W-1:0]    pend_sx_r;
  logic [SY_W-1:0]    pend_sy_r;

  logic               out_valid_r;
  logic               out_last_r;
  logic [DXY_W-1:0]   out_dx_r;
  logic [DXY_W-1:0]   out_dy_r;
  logic [DSIDE_W-1:0] out_side_r;
  logic [SX_W-1:0]    out_sx_r;
  logic [SY_W-1:0]    out_sy_r;

  logic               accept;
  logic               in_map;
  ram_wr_t            wr_req;
  logic [TILE_W-1:0]  rd_tile;
  logic               cell_empty;
  logic               last_cell;
  logic               div_start;
  logic               div_done;
  logic [TILE_W-1:0]  div_quot;
  logic [TPR_W-1:0]   div_rem;
  logic [SIDE_W-1:0]  side_full;
  logic [PROD_W-1:0]  dx_full;
  logic [PROD_W-1:0]  dy_full;
  logic [PROD_W-1:0]  sx_full;
  logic [PROD_W-1:0]  sy_full;
  logic [CNT_W-1:0]   found_inc;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign in_map = (in_col < IN_COORD_W'(MAP_SIDE)) && (in_row < IN_COORD_W'(MAP_SIDE));

  assign wr_req.en   = accept && (in_command == CMD_WRITE) && in_map;
  assign wr_req.addr = cell_addr(in_row[COORD_W-1:0], in_col[COORD_W-1:0]);
  assign wr_req.data = in_tile;

  tmb_map_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_req  (wr_req),
    .rd_addr (cell_addr(row_r, col_r)),
    .rd_tile (rd_tile)
  );

  assign cell_empty = (rd_tile == EMPTY_CELL);
  assign last_cell  = (col_r == LAST_POS) && (row_r == LAST_POS);
  assign div_start  = (state_r == S_CHECK) && !cell_empty;

  tmb_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_tile),
    .divisor  (per_row_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign side_full = SIDE_W'(tpx_r) * SIDE_W'(zoom_r);
  assign dx_full   = PROD_W'(col_r) * PROD_W'(side_r);
  assign dy_full   = PROD_W'(row_r) * PROD_W'(side_r);
  assign sx_full   = PROD_W'(div_rem) * PROD_W'(tpx_r);
  assign sy_full   = PROD_W'(div_quot) * PROD_W'(tpx_r);
  assign found_inc = found_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpx_r  <= TPX_RESET;
      tpr_r  <= TPR_RESET;
      zoom_r <= ZOOM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TILE_PIXELS:   tpx_r  <= cfg_data[TPX_W-1:0];
        REG_TILES_PER_ROW: tpr_r  <= cfg_data[TPR_W-1:0];
        REG_ZOOM_FACTOR:   zoom_r <= cfg_data[ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      found_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_command == CMD_DRAW)) begin
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          side_r     <= side_full;
          per_row_r  <= (tpr_r == '0) ? TPR_W'(1) : tpr_r;
          col_r      <= '0;
          row_r      <= '0;
          found_r    <= '0;
          pend_vld_r <= 1'b0;
          state_r    <= S_READ;
        end
        S_READ: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (!cell_empty) begin
            state_r <= S_DIV;
          end else if (last_cell) begin
            state_r <= pend_vld_r ? S_FLUSH : S_IDLE;
          end else begin
            col_r   <= (col_r == LAST_POS) ? '0 : col_r + COORD_W'(1);
            row_r   <= (col_r == LAST_POS) ? row_r + COORD_W'(1) : row_r;
            state_r <= S_READ;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // The held command goes out only once a later one proves it is not the last.
          if (pend_vld_r) begin
            out_valid_r <= 1'b1;
            out_last_r  <= 1'b0;
            out_dx_r    <= pend_dx_r;
            out_dy_r    <= pend_dy_r;
            out_side_r  <= side_r[DSIDE_W-1:0];
            out_sx_r    <= pend_sx_r;
            out_sy_r    <= pend_sy_r;
          end
          pend_vld_r <= 1'b1;
          pend_dx_r  <= dx_full[DXY_W-1:0];
          pend_dy_r  <= dy_full[DXY_W-1:0];
          pend_sx_r  <= sx_full[SX_W-1:0];
          pend_sy_r  <= sy_full[SY_W-1:0];
          found_r    <= found_inc;
          if ((found_inc == MAX_CNT) || last_cell) begin
            state_r <= S_FLUSH;
          end else begin
            col_r   <= (col_r == LAST_POS) ? '0 : col_r + COORD_W'(1);
            row_r   <= (col_r == LAST_POS) ? row_r + COORD_W'(1) : row_r;
            state_r <= S_READ;
          end
        end
        S_FLUSH: begin
          out_valid_r <= 1'b1;
          out_last_r  <= 1'b1;
          out_dx_r    <= pend_dx_r;
          out_dy_r    <= pend_dy_r;
          out_side_r  <= side_r[DSIDE_W-1:0];
          out_sx_r    <= pend_sx_r;
          out_sy_r    <= pend_sy_r;
          pend_vld_r  <= 1'b0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_last      = out_last_r;
  assign out_dest_x    = out_dx_r;
  assign out_dest_y    = out_dy_r;
  assign out_dest_side = out_side_r;
  assign out_src_x     = out_sx_r;
  assign out_src_y     = out_sy_r;

  `TMB_ASSERT(a_nothing_after_last, out_valid_r && out_last_r |=> !out_valid_r, "result after last")
  `TMB_ASSERT(a_result_from_draw, out_valid_r |-> $past(busy), "result without a draw")
  `TMB_ASSERT(a_blit_cap, found_r <= MAX_CNT, "blit count beyond cap")
  `TMB_ASSERT(a_flush_has_pending, state_r == S_FLUSH |-> pend_vld_r, "closing with nothing held")

endmodule

`default_nettype wire

// File: rtl/tmb_map_ram.sv
`default_nettype none

module tmb_map_ram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tmb_pkg::ram_wr_t              wr_req,
  input  logic [tmb_pkg::ADDR_W-1:0]    rd_addr,
  output logic [tmb_pkg::TILE_W-1:0]    rd_tile
);
  import tmb_pkg::*;

  logic [TILE_W-1:0] mem [CELLS];
  logic [CELLS-1:0]  vld_r;
  logic [TILE_W-1:0] rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_req.en) begin
        vld_r[wr_req.addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // A cell never written since reset reads as empty.
  assign rd_tile = rd_vld_r ? rd_data_r : EMPTY_CELL;

endmodule

`default_nettype wire

// File: rtl/tmb_divider.sv
`default_nettype none

module tmb_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tmb_pkg::TILE_W-1:0]  dividend,
  input  logic [tmb_pkg::TPR_W-1:0]   divisor,
  output logic                        done,
  output logic [tmb_pkg::TILE_W-1:0]  quot,
  output logic [tmb_pkg::TPR_W-1:0]   rem
);
  import tmb_pkg::*;

  localparam int STEPS = 4;

  logic [TILE_W-1:0] q_r, q_nxt;
  logic [TPR_W-1:0]  rem_r, rem_nxt;
  logic [1:0]        cnt_r;
  logic              run_r;
  logic              done_r;

  // Four restoring steps per cycle; the dividend shifts out as quotient bits shift in.
  always_comb begin
    logic [TPR_W:0]  t;
    logic [TILE_W-1:0] q;
    t = {1'b0, rem_r};
    q = q_r;
    for (int k = 0; k < STEPS; k++) begin
      t = {t[TPR_W-1:0], q[TILE_W-1]};
      q = {q[TILE_W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t    = t - {1'b0, divisor};
        q[0] = 1'b1;
      end
    end
    q_nxt   = q;
    rem_nxt = t[TPR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire
